FILE: rtl/atu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atu_pkg
// Shared types, constants and the CORDIC angle table for the affine unit.
// ----------------------------------------------------------------------------
package atu_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_MAX       = 24;

    localparam int CW = 30;

    localparam logic signed [25:0] DEG_90  = 26'sd5898240;
    localparam logic signed [25:0] DEG_180 = 26'sd11796480;
    localparam logic signed [26:0] DEG_360 = 27'sd23592960;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    localparam logic [2:0] CMD_TRANSLATE = 3'd0;
    localparam logic [2:0] CMD_ROTATE    = 3'd1;
    localparam logic [2:0] CMD_SCALE     = 3'd2;
    localparam logic [2:0] CMD_MAP_POINT = 3'd3;
    localparam logic [2:0] CMD_MAP_RECT  = 3'd4;

    // Start control from the sequencer to the CORDIC.
    typedef struct packed {
        logic start;
    } cordic_ctl_t;

    function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
        logic signed [25:0] v;
        unique case (i)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/atu_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atu_cordic
// Iterative rotation-mode CORDIC in degree units, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module atu_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  atu_pkg::cordic_ctl_t      ctl,
    input  wire logic signed [25:0]   angle,
    output logic                      done,
    output logic signed [31:0]        cos_q,
    output logic signed [31:0]        sin_q
);
    import atu_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
    localparam int SH    = CW - FRAC_BITS;

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [27:0] r_reg, r_next;
    logic               neg_reg, neg_next;
    logic [4:0]         i_reg, i_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic signed [26:0] red0, red1;
    logic signed [27:0] red2;
    logic               redneg;
    logic signed [33:0] xs, ys, xf, yf, xr, yr;

    always_comb begin
        // The angle spans less than two turns either way, so a single
        // correction brings it into one turn.
        red0   = 27'(angle);
        if (red0 >= DEG_360) red0 = red0 - DEG_360;
        else if (red0 <= -DEG_360) red0 = red0 + DEG_360;
        if (red0 < 0) red0 = red0 + DEG_360;
        red1   = (red0 >= 27'(DEG_180)) ? red0 - DEG_360 : red0;
        redneg = 1'b0;
        red2   = 28'(red1);
        if (red1 > 27'(DEG_90)) begin
            red2 = 28'(red1) - 28'(DEG_180);
            redneg = 1'b1;
        end else if (red1 < -27'(DEG_90)) begin
            red2 = 28'(red1) + 28'(DEG_180);
            redneg = 1'b1;
        end
    end

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg;
        y_next = y_reg;
        r_next = r_reg;
        i_next = i_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            r_next = red2;
            neg_next = redneg;
            i_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (r_reg >= 0) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                r_next = r_reg - 28'(atan_deg(i_reg));
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                r_next = r_reg + 28'(atan_deg(i_reg));
            end
            i_next = i_reg + 5'd1;
            if (32'(i_reg) == NSTEP - 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        i_reg   <= i_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        xr = (xf + (34'sd1 <<< (SH - 1))) >>> SH;
        yr = (yf + (34'sd1 <<< (SH - 1))) >>> SH;
    end

    assign done  = done_reg;
    assign cos_q = xr[31:0];
    assign sin_q = yr[31:0];

endmodule
`default_nettype wire

FILE: rtl/atu_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atu_mac
// Shared 33x33 multiplier with a wide accumulator, rounding and saturation.
// ----------------------------------------------------------------------------
module atu_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire                      aclk,
    input  wire logic                clr,
    input  wire logic                acc_en,
    input  wire logic signed [32:0]  op_a,
    input  wire logic signed [32:0]  op_b,
    output logic signed [31:0]       result,
    output logic                     clip
);
    localparam int AW = 70;

    logic signed [65:0]   prod_reg;
    logic                 pv_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] rnd, q;

    always_comb begin
        acc_next = acc_reg;
        if (clr) acc_next = AW'(signed'(1)) <<< (FRAC_BITS - 1);
        else if (pv_reg) acc_next = acc_reg + AW'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        pv_reg   <= acc_en;
        acc_reg  <= acc_next;
    end

    always_comb begin
        rnd = acc_reg;
        q   = rnd >>> FRAC_BITS;
        clip = 1'b0;
        result = q[31:0];
        if (q > AW'(64'sd2147483647)) begin
            result = 32'sh7fffffff;
            clip = 1'b1;
        end else if (q < -AW'(64'sd2147483648)) begin
            result = 32'sh80000000;
            clip = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/affine_transform_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_transform_unit_core
// 2D affine matrix register with transform and point/rectangle mapping.
// ----------------------------------------------------------------------------
// The block holds a Q16.16 affine matrix (a b c d e f, identity after reset)
// and accepts one command beat at a time. Translate, rotate and scale
// post-multiply the matrix; map point and map rectangle push coordinates
// through it, the latter returning the bounding box of all four corners.
// Every arithmetic step goes through one shared 33x33 multiplier feeding a
// rounding, saturating accumulator, driven by a small microcode sequencer:
// each sum of products issues its products one by one, then drains the
// multiplier pipeline and stores the sum. Rotate runs the iterative CORDIC
// first. Unused command codes answer on the next cycle.
// The block deasserts s_ready from acceptance until the result beat has been
// taken; one result beat comes out for every command beat.
// ----------------------------------------------------------------------------
module affine_transform_unit_core #(
    parameter int CORDIC_STEPS = atu_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = atu_pkg::FRAC_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_command,
    input  wire logic signed [31:0]  s_x_a,
    input  wire logic signed [31:0]  s_y_a,
    input  wire logic signed [31:0]  s_x_b,
    input  wire logic signed [31:0]  s_y_b,
    input  wire logic signed [25:0]  s_angle,
    input  wire logic signed [31:0]  s_scale_x,
    input  wire logic signed [31:0]  s_scale_y,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_out_x_a,
    output logic signed [31:0]       m_out_y_a,
    output logic signed [31:0]       m_out_x_b,
    output logic signed [31:0]       m_out_y_b,
    output logic                     m_saturated
);
    import atu_pkg::*;

    localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

    // Operand codes for the shared multiplier.
    typedef enum logic [4:0] {
        OP_ZERO, OP_ONE, OP_XA, OP_YA, OP_XB, OP_YB, OP_NXA, OP_NYA,
        OP_SX, OP_SY, OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
        OP_N0, OP_N1, OP_N2, OP_N3, OP_N4, OP_N5, OP_NEGN1
    } opnd_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CORDIC = 6'b000010,
        ST_RUN    = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_STORE  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    // One sum of up to three products, written to a destination slot.
    typedef struct packed {
        logic [1:0] n;
        opnd_t      a0, b0, a1, b1, a2, b2;
        logic [3:0] dst;
    } uop_t;

    // Destinations.
    localparam logic [3:0] D_N4 = 4'd0, D_N5 = 4'd1, D_R0 = 4'd2, D_R1 = 4'd3,
                           D_R2 = 4'd4, D_R3 = 4'd5, D_R4 = 4'd6, D_R5 = 4'd7,
                           D_PX = 4'd8, D_PY = 4'd9;

    state_t             state_reg, state_next;
    logic [2:0]         cmd_reg;
    logic signed [31:0] xa_reg, ya_reg, xb_reg, yb_reg, sx_reg, sy_reg;
    logic signed [31:0] m_reg [6];
    logic signed [31:0] n_reg [6];
    logic signed [31:0] r_reg [6];
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] o_reg [4];
    logic               sat_reg;
    logic [3:0]         pc_reg;
    logic [1:0]         k_reg;
    logic [1:0]         dr_reg;
    logic               mv_reg;

    uop_t               uop;
    logic [3:0]         uop_count;
    opnd_t              sel_a, sel_b;
    logic signed [32:0] op_a, op_b;
    logic               mac_clr, mac_en;
    logic signed [31:0] mac_res;
    logic               mac_clip;

    cordic_ctl_t        cctl;
    logic               c_done;
    logic signed [31:0] c_cos, c_sin;

    // The CORDIC latches its angle in the accepting cycle, straight from the
    // input port.
    atu_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .ctl(cctl), .angle(s_angle),
        .done(c_done), .cos_q(c_cos), .sin_q(c_sin)
    );

    atu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk(aclk), .clr(mac_clr), .acc_en(mac_en), .op_a(op_a), .op_b(op_b),
        .result(mac_res), .clip(mac_clip)
    );

    function automatic uop_t mk(input logic [1:0] n, input opnd_t a0, input opnd_t b0,
                                input opnd_t a1, input opnd_t b1, input opnd_t a2,
                                input opnd_t b2, input logic [3:0] dst);
        uop_t u;
        u.n = n; u.a0 = a0; u.b0 = b0; u.a1 = a1; u.b1 = b1;
        u.a2 = a2; u.b2 = b2; u.dst = dst;
        return u;
    endfunction

    // Microcode: the program for each command. Matrix commands first build
    // the two translation entries of N, then the post-multiply.
    always_comb begin
        uop = mk(2'd0, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, D_PX);
        uop_count = 4'd0;
        unique case (cmd_reg)
            CMD_TRANSLATE, CMD_ROTATE, CMD_SCALE: begin
                uop_count = 4'd8;
                unique case (pc_reg)
                    4'd0: begin
                        if (cmd_reg == CMD_ROTATE)
                            uop = mk(2'd3, OP_XA, OP_ONE, OP_NXA, OP_N0, OP_YA, OP_N1, D_N4);
                        else if (cmd_reg == CMD_SCALE)
                            uop = mk(2'd2, OP_XA, OP_ONE, OP_NXA, OP_SX, OP_ZERO, OP_ZERO,
                                     D_N4);
                        else
                            uop = mk(2'd1, OP_XA, OP_ONE, OP_ZERO, OP_ZERO, OP_ZERO,
                                     OP_ZERO, D_N4);
                    end
                    4'd1: begin
                        if (cmd_reg == CMD_ROTATE)
                            uop = mk(2'd3, OP_YA, OP_ONE, OP_NXA, OP_N1, OP_NYA, OP_N0, D_N5);
                        else if (cmd_reg == CMD_SCALE)
                            uop = mk(2'd2, OP_YA, OP_ONE, OP_NYA, OP_SY, OP_ZERO, OP_ZERO,
                                     D_N5);
                        else
                            uop = mk(2'd1, OP_YA, OP_ONE, OP_ZERO, OP_ZERO, OP_ZERO,
                                     OP_ZERO, D_N5);
                    end
                    4'd2: uop = mk(2'd2, OP_M0, OP_N0, OP_M1, OP_N2, OP_ZERO, OP_ZERO, D_R0);
                    4'd3: uop = mk(2'd2, OP_M0, OP_N1, OP_M1, OP_N3, OP_ZERO, OP_ZERO, D_R1);
                    4'd4: uop = mk(2'd2, OP_M2, OP_N0, OP_M3, OP_N2, OP_ZERO, OP_ZERO, D_R2);
                    4'd5: uop = mk(2'd2, OP_M2, OP_N1, OP_M3, OP_N3, OP_ZERO, OP_ZERO, D_R3);
                    4'd6: uop = mk(2'd3, OP_M4, OP_N0, OP_M5, OP_N2, OP_N4, OP_ONE, D_R4);
                    default: uop = mk(2'd3, OP_M4, OP_N1, OP_M5, OP_N3, OP_N5, OP_ONE, D_R5);
                endcase
            end
            CMD_MAP_POINT, CMD_MAP_RECT: begin
                uop_count = (cmd_reg == CMD_MAP_RECT) ? 4'd8 : 4'd2;
                // Corner order: (xa,ya) (xb,ya) (xa,yb) (xb,yb).
                if (!pc_reg[0])
                    uop = mk(2'd3, pc_reg[1] ? OP_XB : OP_XA, OP_M0,
                             pc_reg[2] ? OP_YB : OP_YA, OP_M2, OP_M4, OP_ONE, D_PX);
                else
                    uop = mk(2'd3, pc_reg[1] ? OP_XB : OP_XA, OP_M1,
                             pc_reg[2] ? OP_YB : OP_YA, OP_M3, OP_M5, OP_ONE, D_PY);
            end
            default: uop_count = 4'd0;
        endcase
    end

    always_comb begin
        unique case (k_reg)
            2'd0:    begin sel_a = uop.a0; sel_b = uop.b0; end
            2'd1:    begin sel_a = uop.a1; sel_b = uop.b1; end
            default: begin sel_a = uop.a2; sel_b = uop.b2; end
        endcase
    end

    function automatic logic signed [32:0] opval(input opnd_t s,
        input logic signed [31:0] xa, input logic signed [31:0] ya,
        input logic signed [31:0] xb, input logic signed [31:0] yb,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [31:0] m0, input logic signed [31:0] m1,
        input logic signed [31:0] m2, input logic signed [31:0] m3,
        input logic signed [31:0] m4, input logic signed [31:0] m5,
        input logic signed [31:0] n0, input logic signed [31:0] n1,
        input logic signed [31:0] n2, input logic signed [31:0] n3,
        input logic signed [31:0] n4, input logic signed [31:0] n5,
        input logic signed [32:0] one);
        logic signed [32:0] v;
        unique case (s)
            OP_ONE:   v = one;
            OP_XA:    v = 33'(xa);
            OP_YA:    v = 33'(ya);
            OP_XB:    v = 33'(xb);
            OP_YB:    v = 33'(yb);
            OP_NXA:   v = -33'(xa);
            OP_NYA:   v = -33'(ya);
            OP_SX:    v = 33'(sx);
            OP_SY:    v = 33'(sy);
            OP_M0:    v = 33'(m0);
            OP_M1:    v = 33'(m1);
            OP_M2:    v = 33'(m2);
            OP_M3:    v = 33'(m3);
            OP_M4:    v = 33'(m4);
            OP_M5:    v = 33'(m5);
            OP_N0:    v = 33'(n0);
            OP_N1:    v = 33'(n1);
            OP_N2:    v = 33'(n2);
            OP_N3:    v = 33'(n3);
            OP_N4:    v = 33'(n4);
            OP_N5:    v = 33'(n5);
            OP_NEGN1: v = -33'(n1);
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign op_a = opval(sel_a, xa_reg, ya_reg, xb_reg, yb_reg, sx_reg, sy_reg,
                        m_reg[0], m_reg[1], m_reg[2], m_reg[3], m_reg[4], m_reg[5],
                        n_reg[0], n_reg[1], n_reg[2], n_reg[3], n_reg[4], n_reg[5], ONE);
    assign op_b = opval(sel_b, xa_reg, ya_reg, xb_reg, yb_reg, sx_reg, sy_reg,
                        m_reg[0], m_reg[1], m_reg[2], m_reg[3], m_reg[4], m_reg[5],
                        n_reg[0], n_reg[1], n_reg[2], n_reg[3], n_reg[4], n_reg[5], ONE);

    assign s_ready = (state_reg == ST_IDLE);
    assign cctl.start = (state_reg == ST_IDLE) && s_valid && (s_command == CMD_ROTATE);
    assign mac_en  = (state_reg == ST_RUN);
    assign mac_clr = (state_reg == ST_IDLE) || (state_reg == ST_STORE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_ROTATE) state_next = ST_CORDIC;
                    else if (s_command > CMD_MAP_RECT) state_next = ST_OUT;
                    else state_next = ST_RUN;
                end
            end
            ST_CORDIC: if (c_done) state_next = ST_RUN;
            ST_RUN:    if (k_reg == uop.n - 2'd1) state_next = ST_DRAIN;
            ST_DRAIN:  if (dr_reg == 2'd1) state_next = ST_STORE;
            ST_STORE:  state_next = (pc_reg == uop_count - 4'd1) ? ST_OUT : ST_RUN;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_reg[0]  <= ONE[31:0];
            m_reg[1]  <= '0;
            m_reg[2]  <= '0;
            m_reg[3]  <= ONE[31:0];
            m_reg[4]  <= '0;
            m_reg[5]  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= (state_next == ST_OUT);
            if (state_reg == ST_STORE && pc_reg == uop_count - 4'd1 &&
                cmd_reg <= CMD_SCALE) begin
                for (int i = 0; i < 4; i++) m_reg[i] <= r_reg[i];
                m_reg[4] <= r_reg[4];
                m_reg[5] <= mac_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg <= s_command;
                xa_reg  <= s_x_a;
                ya_reg  <= s_y_a;
                xb_reg  <= s_x_b;
                yb_reg  <= s_y_b;
                sx_reg  <= s_scale_x;
                sy_reg  <= s_scale_y;
                sat_reg <= 1'b0;
                pc_reg  <= '0;
                k_reg   <= '0;
                dr_reg  <= '0;
                for (int i = 0; i < 4; i++) o_reg[i] <= '0;
                // Fixed entries of N for translate and scale.
                n_reg[0] <= (s_command == CMD_SCALE) ? s_scale_x : ONE[31:0];
                n_reg[1] <= '0;
                n_reg[2] <= '0;
                n_reg[3] <= (s_command == CMD_SCALE) ? s_scale_y : ONE[31:0];
            end
            ST_CORDIC: begin
                if (c_done) begin
                    n_reg[0] <= c_cos;
                    n_reg[1] <= c_sin;
                    n_reg[2] <= -c_sin;
                    n_reg[3] <= c_cos;
                end
            end
            ST_RUN: begin
                k_reg <= (k_reg == uop.n - 2'd1) ? 2'd0 : k_reg + 2'd1;
                dr_reg <= '0;
            end
            ST_DRAIN: dr_reg <= dr_reg + 2'd1;
            ST_STORE: begin
                pc_reg <= pc_reg + 4'd1;
                if (mac_clip) sat_reg <= 1'b1;
                unique case (uop.dst)
                    D_N4: n_reg[4] <= mac_res;
                    D_N5: n_reg[5] <= mac_res;
                    D_R0: r_reg[0] <= mac_res;
                    D_R1: r_reg[1] <= mac_res;
                    D_R2: r_reg[2] <= mac_res;
                    D_R3: r_reg[3] <= mac_res;
                    D_R4: r_reg[4] <= mac_res;
                    D_R5: r_reg[5] <= mac_res;
                    D_PX: px_reg <= mac_res;
                    default: py_reg <= mac_res;
                endcase
                if (uop.dst == D_PX) begin
                    if (pc_reg == '0 || mac_res < o_reg[0]) o_reg[0] <= mac_res;
                    if (pc_reg == '0 || mac_res > o_reg[2]) o_reg[2] <= mac_res;
                end
                if (uop.dst == D_PY) begin
                    if (pc_reg == 4'd1 || mac_res < o_reg[1]) o_reg[1] <= mac_res;
                    if (pc_reg == 4'd1 || mac_res > o_reg[3]) o_reg[3] <= mac_res;
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = mv_reg && (state_reg == ST_OUT);
    assign m_saturated = sat_reg;
    assign m_out_x_a   = (cmd_reg == CMD_MAP_POINT) ? px_reg :
                         (cmd_reg == CMD_MAP_RECT) ? o_reg[0] : '0;
    assign m_out_y_a   = (cmd_reg == CMD_MAP_POINT) ? py_reg :
                         (cmd_reg == CMD_MAP_RECT) ? o_reg[1] : '0;
    assign m_out_x_b   = (cmd_reg == CMD_MAP_RECT) ? o_reg[2] : '0;
    assign m_out_y_b   = (cmd_reg == CMD_MAP_RECT) ? o_reg[3] : '0;

endmodule
`default_nettype wire
